// ===== src/lkv_pkg.sv =====
// Package for the LRU key/value cache: widths, default sizes and the request beat type.
// Used by the channel interfaces, the request queue, the cache engine and the top level.
package lkv_pkg;

  localparam int unsigned LKV_ENTRIES = 64;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] write_value;
  } lkv_req_t;

endpackage

// ===== src/lkv_req_if.sv =====
// Request channel: valid/ready handshake carrying one get or put beat.
// Depends on lkv_pkg for field widths.
interface lkv_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [lkv_pkg::KEY_W-1:0]   lookup_key;
  logic [lkv_pkg::VAL_W-1:0]   write_value;

  modport source(output valid, req_type, lookup_key, write_value, input ready);
  modport sink(input valid, req_type, lookup_key, write_value, output ready);
endinterface

// ===== src/lkv_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one hit flag and read value beat.
// Depends on lkv_pkg for field widths.
interface lkv_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lkv_pkg::VAL_W-1:0]   read_value;

  modport source(output valid, hit, read_value, input ready);
  modport sink(input valid, hit, read_value, output ready);
endinterface

// ===== src/lkv_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lkv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== src/lkv_front.sv =====
// Front end: a two-beat request queue that decouples the request channel from the engine.
// Depends on lkv_pkg and lkv_req_if.
module lkv_front (
  input  logic              clk,
  input  logic              rst,
  lkv_req_if.sink           req,
  output lkv_pkg::lkv_req_t head,
  output logic              head_valid,
  input  logic              pop
);
  import lkv_pkg::*;

  lkv_req_t   q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;

  assign req.ready  = (count != 2'd2);
  assign push       = req.valid && req.ready;
  assign head       = q[rd_ptr];
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{req_type: req.req_type, lookup_key: req.lookup_key,
                     write_value: req.write_value};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("request queue popped while empty");
endmodule

// ===== src/lkv_engine.sv =====
// Back end: key match over the slot registers, recency list upkeep in link RAMs,
// eviction and insertion, and the result register. Depends on lkv_pkg and lkv_ram.
module lkv_engine #(
  parameter int unsigned ENTRIES = lkv_pkg::LKV_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lkv_pkg::lkv_req_t         head,
  input  logic                      head_valid,
  output logic                      pop,
  input  logic [lkv_pkg::CAP_W-1:0] capacity,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic [lkv_pkg::VAL_W-1:0] out_value,
  input  logic                      out_ready
);
  import lkv_pkg::*;

  localparam int unsigned SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned UW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = (UW > CAP_W) ? UW : CAP_W;
  localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LINK  = 6'b000010,
    S_MOVE  = 6'b000100,
    S_EVICT = 6'b001000,
    S_INS   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             st;
  logic [KEY_W-1:0]   slot_key [ENTRIES];
  logic [ENTRIES-1:0] slot_valid;
  logic [UW-1:0]      used;
  logic [SW-1:0]      oldest;
  logic [SW-1:0]      newest;
  logic               cur_put;
  logic               cur_hit;
  logic [SW-1:0]      cur_slot;
  logic [KEY_W-1:0]   cur_key;
  logic [VAL_W-1:0]   cur_val;

  logic               m_hit;
  logic [SW-1:0]      m_slot;
  logic               f_any;
  logic [SW-1:0]      f_slot;
  logic [CW-1:0]      cap_x;
  logic [CW-1:0]      eff_cap;
  logic               full;
  logic               take;

  logic               val_we, val_re;
  logic [SW-1:0]      val_waddr, val_raddr;
  logic [VAL_W-1:0]   val_wdata, val_rdata;
  logic               nl_we, ol_we, ln_re;
  logic [SW-1:0]      nl_waddr, ol_waddr, ln_raddr;
  logic [SW-1:0]      nl_wdata, ol_wdata, nl_rdata, ol_rdata;

  // Lowest matching slot wins; keys are unique among valid slots anyway.
  always_comb begin
    m_hit  = 1'b0;
    m_slot = '0;
    f_any  = 1'b0;
    f_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == head.lookup_key) begin
        m_hit  = 1'b1;
        m_slot = SW'(i);
      end
      if (!slot_valid[i]) begin
        f_any  = 1'b1;
        f_slot = SW'(i);
      end
    end
  end

  always_comb begin
    cap_x = CW'(capacity);
    if (cap_x == '0) begin
      eff_cap = CW'(1);
    end else if (cap_x > ENT_C) begin
      eff_cap = ENT_C;
    end else begin
      eff_cap = cap_x;
    end
    full = (CW'(used) >= eff_cap);
  end

  assign take = (st == S_IDLE) && head_valid;
  assign pop  = take;

  always_comb begin
    val_we    = 1'b0;
    val_waddr = m_slot;
    val_wdata = head.write_value;
    val_re    = 1'b0;
    val_raddr = m_slot;
    nl_we     = 1'b0;
    nl_waddr  = '0;
    nl_wdata  = '0;
    ol_we     = 1'b0;
    ol_waddr  = '0;
    ol_wdata  = '0;
    ln_re     = 1'b0;
    ln_raddr  = m_hit ? m_slot : oldest;
    unique case (st)
      S_IDLE: begin
        if (take) begin
          ln_re  = 1'b1;
          val_we = m_hit && (head.req_type == REQ_PUT);
          val_re = m_hit && (head.req_type == REQ_GET);
        end
      end
      S_LINK: begin
        // Unlink the slot: its older neighbor now points past it.
        if (cur_slot != oldest) begin
          nl_we    = 1'b1;
          nl_waddr = ol_rdata;
          nl_wdata = nl_rdata;
        end
        ol_we    = 1'b1;
        ol_waddr = nl_rdata;
        ol_wdata = ol_rdata;
      end
      S_MOVE: begin
        ol_we    = 1'b1;
        ol_waddr = cur_slot;
        ol_wdata = newest;
        nl_we    = 1'b1;
        nl_waddr = newest;
        nl_wdata = cur_slot;
      end
      S_EVICT: begin
      end
      S_INS: begin
        if (f_any) begin
          val_we    = 1'b1;
          val_waddr = f_slot;
          val_wdata = cur_val;
          if (used != '0) begin
            ol_we    = 1'b1;
            ol_waddr = f_slot;
            ol_wdata = newest;
            nl_we    = 1'b1;
            nl_waddr = newest;
            nl_wdata = f_slot;
          end
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_put  <= head.req_type;
      cur_hit  <= m_hit;
      cur_slot <= m_slot;
      cur_key  <= head.lookup_key;
      cur_val  <= head.write_value;
    end
    if (st == S_INS && f_any) begin
      slot_key[f_slot] <= cur_key;
    end
    if (rst) begin
      st         <= S_IDLE;
      slot_valid <= '0;
      used       <= '0;
      oldest     <= '0;
      newest     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (st == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (take) begin
            if (m_hit) begin
              st <= (m_slot == newest) ? S_DONE : S_LINK;
            end else if (head.req_type == REQ_PUT) begin
              st <= (full && used != '0) ? S_EVICT : S_INS;
            end else begin
              st <= S_DONE;
            end
          end
        end
        S_LINK: begin
          if (cur_slot == oldest) oldest <= nl_rdata;
          st <= S_MOVE;
        end
        S_MOVE: begin
          newest <= cur_slot;
          st     <= S_DONE;
        end
        S_EVICT: begin
          // The link read issued at acceptance holds the next-oldest slot.
          slot_valid[oldest] <= 1'b0;
          used <= used - UW'(1);
          if (used != UW'(1)) oldest <= nl_rdata;
          st <= S_INS;
        end
        S_INS: begin
          if (f_any) begin
            slot_valid[f_slot] <= 1'b1;
            used   <= used + UW'(1);
            newest <= f_slot;
            if (used == '0) oldest <= f_slot;
          end
          st <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_DONE && (!out_valid || out_ready)) begin
      out_hit   <= cur_hit;
      out_value <= (cur_hit && cur_put == REQ_GET) ? val_rdata : '0;
    end
  end

  lkv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .re(val_re), .raddr(val_raddr), .rdata(val_rdata)
  );

  lkv_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_newer_ram (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .re(ln_re), .raddr(ln_raddr), .rdata(nl_rdata)
  );

  lkv_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_older_ram (
    .clk(clk), .we(ol_we), .waddr(ol_waddr), .wdata(ol_wdata),
    .re(ln_re), .raddr(ln_raddr), .rdata(ol_rdata)
  );

  assert property (@(posedge clk) disable iff (rst) used <= UW'(ENTRIES))
    else $error("occupancy exceeds the number of slots");
  assert property (@(posedge clk) disable iff (rst) $countones(slot_valid) == int'(used))
    else $error("valid map disagrees with occupancy");
  assert property (@(posedge clk) disable iff (rst) pop |-> st == S_IDLE)
    else $error("request taken while the engine is busy");
  assert property (@(posedge clk) disable iff (rst)
    (st == S_DONE && (!out_valid || out_ready)) |=> out_valid && st == S_IDLE)
    else $error("finished result not presented");
endmodule

// ===== src/lru_key_value_cache_top.sv =====
// Top level of the LRU key/value cache: capacity register, request queue and engine.
// Depends on lkv_pkg, lkv_req_if, lkv_rsp_if, lkv_front and lkv_engine.
//
// Usage: requests arrive as beats on req (req_type 0 = get, 1 = put, a 16-bit key
// and a 32-bit value for puts). Every request yields exactly one response beat on
// rsp: hit tells whether the key was present, read_value carries the stored value
// on a get hit and zero otherwise. Responses come back in request order.
// The capacity register (cfg_we, cfg_wdata) sets how many entries are held before
// the least recently used one is evicted; zero acts as one, values above ENTRIES
// act as ENTRIES. The user must write it only while no request is outstanding; the
// block itself does not enforce this. The engine works on one request at a time: a
// get miss or a hit on the newest entry goes straight to done, a hit elsewhere passes
// link and move (two link RAM write passes), a put miss passes insert, after evict
// when it evicts. A two-beat request queue keeps the request side open meanwhile.
// Reset empties the cache, sets capacity to 64 and needs no clearing pass.
// When the receiver stalls, the result is held in the output register and the
// engine waits before presenting the next one; requests still queue up to two beats.
module lru_key_value_cache_top #(
  parameter int unsigned ENTRIES = lkv_pkg::LKV_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst,
  lkv_req_if.sink                   req,
  lkv_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);
  import lkv_pkg::*;

  logic [CAP_W-1:0] capacity;
  lkv_req_t         head;
  logic             head_valid;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  lkv_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .head(head), .head_valid(head_valid), .pop(pop)
  );

  lkv_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk(clk), .rst(rst),
    .head(head), .head_valid(head_valid), .pop(pop),
    .capacity(capacity),
    .out_valid(rsp.valid), .out_hit(rsp.hit), .out_value(rsp.read_value),
    .out_ready(rsp.ready)
  );
endmodule
